### design/rrp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_pkg
// shared widths, generator constants and controller/datapath interface types
// ----------------------------------------------------------------------------
package rrp_pkg;

  localparam int MAX_PROCS = 64;
  localparam int ID_W      = $clog2(MAX_PROCS);
  localparam int CNT_W     = $clog2(MAX_PROCS + 1);

  // splitmix64 generator
  localparam int          RNG_W      = 64;
  localparam int          HALF_W     = RNG_W / 2;
  localparam logic [63:0] GOLDEN_INC = 64'h9e3779b97f4a7c15;
  localparam logic [63:0] MIX_MUL_A  = 64'hbf58476d1ce4e5b9;
  localparam logic [63:0] MIX_MUL_B  = 64'h94d049bb133111eb;
  localparam int          SHIFT_PRE  = 30;
  localparam int          SHIFT_MID  = 27;
  localparam int          SHIFT_POST = 31;

  // remainder unit: one byte of the dividend per cycle
  localparam int DIV_BITS  = 8;
  localparam int DIV_STEPS = RNG_W / DIV_BITS;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // item kinds
  localparam logic OP_PICK   = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  // partial products of the 64x64 low-half multiply
  localparam logic [1:0] MUL_LL = 2'd0;
  localparam logic [1:0] MUL_LH = 2'd1;
  localparam logic [1:0] MUL_HL = 2'd2;

  typedef struct packed {
    logic       take_item;
    logic       rng_adv;
    logic       mul_en;
    logic [1:0] mul_step;
    logic       mul_pass;
    logic       acc_load;
    logic       acc_add;
    logic       mix_en;
    logic       div_en;
    logic       pick_setup;
    logic       rd_pos;
    logic       upd_apply;
    logic       rd_slot;
    logic       wr_first;
    logic       wr_second;
    logic       load_out;
  } rrp_cmd_t;

  typedef struct packed {
    logic pool_empty;
    logic upd_change;
    logic out_free;
  } rrp_sts_t;

endpackage

### design/rrp_tables.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_tables
// slot table and its inverse, with per-entry valid bits giving identity reset
// ----------------------------------------------------------------------------
module rrp_tables (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  rd_pos,
  input  logic [rrp_pkg::ID_W-1:0] pos_addr,
  input  logic                  rd_slot,
  input  logic [rrp_pkg::ID_W-1:0] addr_a,
  input  logic [rrp_pkg::ID_W-1:0] addr_b,
  input  logic                  wr_first,
  input  logic                  wr_second,
  output logic [rrp_pkg::ID_W-1:0] pos_val,
  output logic [rrp_pkg::ID_W-1:0] val_a
);
  import rrp_pkg::*;

  logic [ID_W-1:0]      slot_mem [MAX_PROCS];
  logic [ID_W-1:0]      pos_mem  [MAX_PROCS];
  logic [MAX_PROCS-1:0] slot_vld;
  logic [MAX_PROCS-1:0] pos_vld;

  logic [ID_W-1:0] sa_q, sb_q, sa_addr, sb_addr, p_q, p_addr, val_b;
  logic            sa_v, sb_v, p_v;

  // unwritten entries read back as their own index
  assign val_a   = sa_v ? sa_q : sa_addr;
  assign val_b   = sb_v ? sb_q : sb_addr;
  assign pos_val = p_v  ? p_q  : p_addr;

  // swap in two writes: slot a and the position of its old owner, then slot b
  always_ff @(posedge clk) begin
    if (wr_first) begin
      slot_mem[addr_a] <= val_b;
      pos_mem[val_a]   <= addr_b;
    end else if (wr_second) begin
      slot_mem[addr_b] <= val_a;
      pos_mem[val_b]   <= addr_a;
    end
    if (rd_slot) begin
      sa_q    <= slot_mem[addr_a];
      sb_q    <= slot_mem[addr_b];
      sa_v    <= slot_vld[addr_a];
      sb_v    <= slot_vld[addr_b];
      sa_addr <= addr_a;
      sb_addr <= addr_b;
    end
    if (rd_pos) begin
      p_q    <= pos_mem[pos_addr];
      p_v    <= pos_vld[pos_addr];
      p_addr <= pos_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_vld <= '0;
      pos_vld  <= '0;
    end else if (wr_first) begin
      slot_vld[addr_a] <= 1'b1;
      pos_vld[val_a]   <= 1'b1;
    end else if (wr_second) begin
      slot_vld[addr_b] <= 1'b1;
      pos_vld[val_b]   <= 1'b1;
    end
  end

endmodule

### design/rrp_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_dp
// generator, shared multiplier, remainder unit, pool count, slot tables and result register
// ----------------------------------------------------------------------------
module rrp_dp (
  input  logic                      clk,
  input  logic                      rst,
  input  rrp_pkg::rrp_cmd_t         cmd,
  output rrp_pkg::rrp_sts_t         sts,
  input  logic                      in_op,
  input  logic [rrp_pkg::ID_W-1:0]  in_pid,
  input  logic                      in_want,
  input  logic                      seed_wr_en,
  input  logic [rrp_pkg::RNG_W-1:0] seed_wr_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic                      out_granted,
  output logic [rrp_pkg::ID_W-1:0]  out_chosen,
  output logic [rrp_pkg::CNT_W-1:0] out_count
);
  import rrp_pkg::*;

  logic [RNG_W-1:0]  rng_state, rng_sum, z, acc, prod, prod_next, mul_k;
  logic [HALF_W-1:0] mul_a, mul_b;
  logic [ID_W-1:0]   rem, rem_next, pid_q, swap_a, swap_b, pos_val, val_a;
  logic [CNT_W-1:0]  count;
  logic              op_q, want_q, granted_q, runnable;
  logic [ID_W-1:0]   chosen_q;

  assign rng_sum = rng_state + GOLDEN_INC;
  assign mul_k   = cmd.mul_pass ? MIX_MUL_B : MIX_MUL_A;
  assign mul_a   = (cmd.mul_step == MUL_HL) ? z[RNG_W-1:HALF_W] : z[HALF_W-1:0];
  assign mul_b   = (cmd.mul_step == MUL_LH) ? mul_k[RNG_W-1:HALF_W] : mul_k[HALF_W-1:0];
  assign prod_next = RNG_W'(mul_a) * RNG_W'(mul_b);

  always_ff @(posedge clk) begin
    if (rst) begin
      rng_state <= '0;
    end else if (seed_wr_en) begin
      rng_state <= seed_wr_data;
    end else if (cmd.rng_adv) begin
      rng_state <= rng_sum;
    end
  end

  // remainder of z by the pool count, one byte per cycle
  always_comb begin
    logic [CNT_W-1:0] r;
    r = {1'b0, rem};
    for (int i = 0; i < DIV_BITS; i++) begin
      r = {r[ID_W-1:0], z[RNG_W-1-i]};
      if (r >= count) begin
        r = r - count;
      end
    end
    rem_next = r[ID_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.rng_adv) begin
      z <= rng_sum ^ (rng_sum >> SHIFT_PRE);
    end else if (cmd.mix_en) begin
      z <= cmd.mul_pass ? (acc ^ (acc >> SHIFT_POST)) : (acc ^ (acc >> SHIFT_MID));
    end else if (cmd.div_en) begin
      z <= z << DIV_BITS;
    end
    if (cmd.mul_en) begin
      prod <= prod_next;
    end
    if (cmd.acc_load) begin
      acc <= prod;
    end else if (cmd.acc_add) begin
      acc[RNG_W-1:HALF_W] <= acc[RNG_W-1:HALF_W] + prod[HALF_W-1:0];
    end
    if (cmd.rng_adv) begin
      rem <= '0;
    end else if (cmd.div_en) begin
      rem <= rem_next;
    end
  end

  assign runnable = {1'b0, pos_val} < count;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (cmd.pick_setup || (cmd.upd_apply && runnable)) begin
      count <= count - CNT_W'(1);
    end else if (cmd.upd_apply) begin
      count <= count + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_item) begin
      op_q      <= in_op;
      pid_q     <= in_pid;
      want_q    <= in_want;
      granted_q <= 1'b0;
      chosen_q  <= '0;
    end else if (cmd.pick_setup) begin
      granted_q <= 1'b1;
    end else if (cmd.wr_first && granted_q) begin
      chosen_q <= val_a;
    end
    if (cmd.pick_setup) begin
      swap_a <= rem;
      swap_b <= ID_W'(count - CNT_W'(1));
    end else if (cmd.upd_apply) begin
      swap_a <= pos_val;
      swap_b <= runnable ? ID_W'(count - CNT_W'(1)) : count[ID_W-1:0];
    end
  end

  rrp_tables u_tables (
    .clk       (clk),
    .rst       (rst),
    .rd_pos    (cmd.rd_pos),
    .pos_addr  (pid_q),
    .rd_slot   (cmd.rd_slot),
    .addr_a    (swap_a),
    .addr_b    (swap_b),
    .wr_first  (cmd.wr_first),
    .wr_second (cmd.wr_second),
    .pos_val   (pos_val),
    .val_a     (val_a)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_granted <= granted_q;
      out_chosen  <= chosen_q;
      out_count   <= count;
    end
  end

  assign sts.pool_empty = (count == '0);
  assign sts.upd_change = op_q && (runnable != want_q);
  assign sts.out_free   = !out_valid || out_ready;

endmodule

### design/rrp_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_ctrl
// sequencer for pick and update items
// ----------------------------------------------------------------------------
module rrp_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic              in_op,
  output logic              in_ready,
  input  rrp_pkg::rrp_sts_t sts,
  output rrp_pkg::rrp_cmd_t cmd
);
  import rrp_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_ADV   = 4'd1;
  localparam logic [3:0] S_MUL0  = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_MUL3  = 4'd5;
  localparam logic [3:0] S_MIX   = 4'd6;
  localparam logic [3:0] S_DIV   = 4'd7;
  localparam logic [3:0] S_PSET  = 4'd8;
  localparam logic [3:0] S_RDPOS = 4'd9;
  localparam logic [3:0] S_DEC   = 4'd10;
  localparam logic [3:0] S_RDS   = 4'd11;
  localparam logic [3:0] S_WR1   = 4'd12;
  localparam logic [3:0] S_WR2   = 4'd13;
  localparam logic [3:0] S_FIN   = 4'd14;

  logic [3:0]           state, state_next;
  logic                 pass, pass_next;
  logic [DIV_CNT_W-1:0] div_cnt, div_cnt_next;

  assign in_ready = (state == S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      pass    <= 1'b0;
      div_cnt <= '0;
    end else begin
      state   <= state_next;
      pass    <= pass_next;
      div_cnt <= div_cnt_next;
    end
  end

  always_comb begin
    state_next   = state;
    pass_next    = pass;
    div_cnt_next = div_cnt;
    cmd          = '0;
    cmd.mul_pass = pass;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.take_item = 1'b1;
          if (in_op == OP_UPDATE) begin
            state_next = S_RDPOS;
          end else if (sts.pool_empty) begin
            state_next = S_FIN;
          end else begin
            state_next = S_ADV;
          end
        end
      end
      S_ADV: begin
        cmd.rng_adv = 1'b1;
        pass_next   = 1'b0;
        state_next  = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_LL;
        state_next   = S_MUL1;
      end
      S_MUL1: begin
        cmd.acc_load = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_LH;
        state_next   = S_MUL2;
      end
      S_MUL2: begin
        cmd.acc_add  = 1'b1;
        cmd.mul_en   = 1'b1;
        cmd.mul_step = MUL_HL;
        state_next   = S_MUL3;
      end
      S_MUL3: begin
        cmd.acc_add = 1'b1;
        state_next  = S_MIX;
      end
      S_MIX: begin
        cmd.mix_en = 1'b1;
        if (!pass) begin
          pass_next  = 1'b1;
          state_next = S_MUL0;
        end else begin
          div_cnt_next = '0;
          state_next   = S_DIV;
        end
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (div_cnt == DIV_CNT_W'(DIV_STEPS - 1)) begin
          state_next = S_PSET;
        end else begin
          div_cnt_next = div_cnt + DIV_CNT_W'(1);
        end
      end
      S_PSET: begin
        cmd.pick_setup = 1'b1;
        state_next     = S_RDS;
      end
      S_RDPOS: begin
        cmd.rd_pos = 1'b1;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (sts.upd_change) begin
          cmd.upd_apply = 1'b1;
          state_next    = S_RDS;
        end else begin
          state_next = S_FIN;
        end
      end
      S_RDS: begin
        cmd.rd_slot = 1'b1;
        state_next  = S_WR1;
      end
      S_WR1: begin
        cmd.wr_first = 1'b1;
        state_next   = S_WR2;
      end
      S_WR2: begin
        cmd.wr_second = 1'b1;
        state_next    = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

### design/random_runnable_picker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// random_runnable_picker
// random choice among runnable processes kept in a permuted slot table
// ----------------------------------------------------------------------------
// one item at a time, the next item taken in the cycle after the result is loaded;
// no-change updates skip the tables; empty-pool picks go straight to the result
// pick time is set by the shared 32x32 multiplier (two products) and the
// byte-per-cycle remainder unit; updates by the table read and 2 writes
// reset: pool empty, generator state zero, slot table reads as identity at once
// through per-entry valid bits, so no clearing pass is needed
module random_runnable_picker (
  input  logic        clk,
  input  logic        rst,
  // config: generator seed, writing it reloads the generator
  input  logic        seed_wr_en,
  input  logic [63:0] seed_wr_data,
  // input item stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [5:0] proc_id, [6] make_runnable, [7] zero
  input  logic        s_axis_tuser,   // [0] op
  // result item stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [5:0] chosen_id, [12:6] runnable_count, [15:13] zero
  output logic        m_axis_tuser    // [0] granted
);
  import rrp_pkg::*;

  rrp_cmd_t         cmd;
  rrp_sts_t         sts;
  logic [ID_W-1:0]  out_chosen;
  logic [CNT_W-1:0] out_count;

  // controller sees the item kind straight from the port to branch on accept
  rrp_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_axis_tvalid),
    .in_op    (s_axis_tuser),
    .in_ready (s_axis_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  // datapath holds the generator, pool count, tables and the result register,
  // so a finished result can wait downstream while the next item comes in
  rrp_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .in_op        (s_axis_tuser),
    .in_pid       (s_axis_tdata[ID_W-1:0]),
    .in_want      (s_axis_tdata[ID_W]),
    .seed_wr_en   (seed_wr_en),
    .seed_wr_data (seed_wr_data),
    .out_valid    (m_axis_tvalid),
    .out_ready    (m_axis_tready),
    .out_granted  (m_axis_tuser),
    .out_chosen   (out_chosen),
    .out_count    (out_count)
  );

  // pack the result fields, zero fill to whole bytes
  assign m_axis_tdata = {3'b000, out_count, out_chosen};

endmodule

### dv/tb_random_runnable_picker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_random_runnable_picker
// self-checking bench for the random runnable picker: a local scheduler model
// (slot table, pool count, splitmix64 state) predicts one result per item and
// the result stream is checked item by item, in order, under random stalls
// ----------------------------------------------------------------------------
module tb_random_runnable_picker;
  import rrp_pkg::*;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no item moving on either side
  localparam int DRAIN_CYCLES   = 32;    // longer than the slowest pick
  localparam int MAX_REPORTS    = 10;

  // one result item as the model sees it
  typedef struct packed {
    logic             granted;
    logic [ID_W-1:0]  chosen_id;
    logic [CNT_W-1:0] runnable_count;
  } grant_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        seed_wr_en    = 1'b0;
  logic [63:0] seed_wr_data  = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;   // [5:0] proc_id, [6] make_runnable, [7] zero
  logic        s_axis_tuser  = 1'b0; // [0] op
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [15:0] m_axis_tdata;         // [5:0] chosen_id, [12:6] runnable_count, [15:13] zero
  logic        m_axis_tuser;         // [0] granted

  // scheduler model state
  logic [ID_W-1:0] slot_ids [MAX_PROCS];
  int              pool_cnt;
  logic [63:0]     gen_state;

  // results still owed by the block, oldest first
  grant_t pending_grants [$];

  int     err_count   = 0;
  int     idle_cycles = 0;
  int     stall_left  = 0;
  bit     src_calm    = 1'b0;  // sender drives back to back
  bit     sink_calm   = 1'b0;  // receiver never stalls
  grant_t got_r;
  grant_t exp_r;

  random_runnable_picker i_dut (
    .clk           (clk),
    .rst           (rst),
    .seed_wr_en    (seed_wr_en),
    .seed_wr_data  (seed_wr_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // mostly short idles, now and then a long one
  function automatic int gap_draw();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 4);
    return $urandom_range(8, 40);
  endfunction

  // model of one item: advances the scheduler state and queues its result
  function automatic void schedule_item(logic op, logic [ID_W-1:0] pid, logic want);
    grant_t          r;
    logic [63:0]     z;
    logic [ID_W-1:0] tmp;
    int              idx;
    int              pos;
    r = '0;
    if (op == OP_PICK) begin
      // empty pool: no grant and the generator holds still
      if (pool_cnt != 0) begin
        gen_state = gen_state + GOLDEN_INC;
        z = gen_state;
        z = (z ^ (z >> SHIFT_PRE)) * MIX_MUL_A;
        z = (z ^ (z >> SHIFT_MID)) * MIX_MUL_B;
        z = z ^ (z >> SHIFT_POST);
        idx = int'(z % 64'(pool_cnt));
        r.granted   = 1'b1;
        r.chosen_id = slot_ids[idx];
        // granted process drops out of the pool
        pool_cnt--;
        tmp                = slot_ids[idx];
        slot_ids[idx]      = slot_ids[pool_cnt];
        slot_ids[pool_cnt] = tmp;
      end
    end else begin
      pos = 0;
      while (pos < MAX_PROCS && slot_ids[pos] != pid) pos++;
      if (pos < MAX_PROCS) begin
        // asking for the state a process already has changes nothing
        if (pos < pool_cnt && !want) begin
          pool_cnt--;
          tmp                = slot_ids[pos];
          slot_ids[pos]      = slot_ids[pool_cnt];
          slot_ids[pool_cnt] = tmp;
        end else if (pos >= pool_cnt && want) begin
          tmp                = slot_ids[pos];
          slot_ids[pos]      = slot_ids[pool_cnt];
          slot_ids[pool_cnt] = tmp;
          pool_cnt++;
        end
      end
    end
    r.runnable_count = CNT_W'(pool_cnt);
    pending_grants.push_back(r);
  endfunction

  // drive one item and wait for the handshake
  task automatic send_item(input logic op, input logic [ID_W-1:0] pid, input logic want);
    int gap;
    gap = src_calm ? 0 : gap_draw();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, want, pid};
    s_axis_tuser  <= op;
    do @(posedge clk); while (!s_axis_tready);
    schedule_item(op, pid, want);
  endtask

  // block is idle once every owed result has come back
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (pending_grants.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // seed write reloads the generator, only done while idle
  task automatic load_seed(input logic [63:0] value);
    wait_drained();
    seed_wr_en   <= 1'b1;
    seed_wr_data <= value;
    @(posedge clk);
    gen_state = value;
    seed_wr_en <= 1'b0;
  endtask

  task automatic report_error(input string what, input grant_t e, input grant_t g);
    err_count++;
    if (err_count <= MAX_REPORTS)
      $display("%s: exp granted=%0d id=%0d count=%0d, got granted=%0d id=%0d count=%0d",
               what, e.granted, e.chosen_id, e.runnable_count,
               g.granted, g.chosen_id, g.runnable_count);
  endtask

  // picks and a no-op update straight out of reset
  task automatic test_empty_pool();
    send_item(OP_PICK, 6'd0, 1'b0);
    send_item(OP_PICK, 6'd63, 1'b1);
    send_item(OP_UPDATE, 6'd5, 1'b0);
  endtask

  // lowest and highest ids in and out, repeated requests change nothing
  task automatic test_update_edges();
    send_item(OP_UPDATE, 6'd0, 1'b1);
    send_item(OP_UPDATE, 6'd63, 1'b1);
    send_item(OP_UPDATE, 6'd63, 1'b1);
    send_item(OP_UPDATE, 6'd0, 1'b0);
    send_item(OP_UPDATE, 6'd0, 1'b0);
    send_item(OP_UPDATE, 6'd63, 1'b0);
  endtask

  // all-ones and zero seeds, drain the pool down to an empty pick
  task automatic test_seed_extremes();
    load_seed(64'hffff_ffff_ffff_ffff);
    send_item(OP_UPDATE, 6'd0, 1'b1);
    send_item(OP_UPDATE, 6'd21, 1'b1);
    send_item(OP_UPDATE, 6'd42, 1'b1);
    send_item(OP_UPDATE, 6'd63, 1'b1);
    repeat (5) send_item(OP_PICK, 6'd0, 1'b0);
    load_seed(64'h0);
    send_item(OP_UPDATE, 6'd7, 1'b1);
    send_item(OP_UPDATE, 6'd56, 1'b1);
    repeat (2) send_item(OP_PICK, 6'd63, 1'b1);
  endtask

  // random traffic steered towards a target pool size
  task automatic run_random_phase(input int n_items, input int target, input int pick_pct);
    logic            op;
    logic            want;
    logic [ID_W-1:0] pid;
    for (int i = 0; i < n_items; i++) begin
      // stretches with and without idling on either side
      if (i % 100 == 0) begin
        src_calm  = ($urandom_range(0, 3) == 0);
        sink_calm = ($urandom_range(0, 3) == 0);
      end
      op   = ($urandom_range(0, 99) < pick_pct) ? OP_PICK : OP_UPDATE;
      want = (pool_cnt < target) ? ($urandom_range(0, 9) < 8) : ($urandom_range(0, 9) < 3);
      pid  = $urandom_range(0, MAX_PROCS - 1);
      // mostly aim at a process whose state really changes
      if ($urandom_range(0, 9) < 7) begin
        if (want && pool_cnt < MAX_PROCS)
          pid = slot_ids[$urandom_range(pool_cnt, MAX_PROCS - 1)];
        else if (!want && pool_cnt > 0)
          pid = slot_ids[$urandom_range(0, pool_cnt - 1)];
      end
      send_item(op, pid, want);
    end
    src_calm  = 1'b0;
    sink_calm = 1'b0;
  endtask

  task automatic test_random_phases();
    load_seed({$urandom, $urandom});
    run_random_phase(420, 4, 45);
    load_seed({$urandom, $urandom});
    run_random_phase(420, 32, 35);
    load_seed(64'hffff_ffff_ffff_ffff);
    run_random_phase(420, MAX_PROCS, 15);
    load_seed({$urandom, $urandom});
    run_random_phase(420, 16, 40);
  endtask

  // receiver with random stalls
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left    <= stall_left - 1;
    end else begin
      m_axis_tready <= 1'b1;
      if (!sink_calm) stall_left <= gap_draw();
    end
  end

  // result checker, in order against the model
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      got_r.granted        = m_axis_tuser;
      got_r.chosen_id      = m_axis_tdata[ID_W-1:0];
      got_r.runnable_count = m_axis_tdata[ID_W+CNT_W-1:ID_W];
      if (pending_grants.size() == 0) begin
        report_error("unexpected result", '0, got_r);
      end else begin
        exp_r = pending_grants.pop_front();
        if (got_r !== exp_r) report_error("result mismatch", exp_r, got_r);
      end
    end
  end

  // watchdog on cycles where no item moves
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    // model reset: identity table, empty pool, seed zero
    for (int i = 0; i < MAX_PROCS; i++) slot_ids[i] = ID_W'(i);
    pool_cnt  = 0;
    gen_state = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_pool();
    test_update_edges();
    test_seed_extremes();
    test_random_phases();

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
